// ===== rtl/core/ufd_pkg.sv =====
// ----------------------------------------------------------------------------
// Form decoder package
// Shared types, character constants and hex helpers for the urlencoded form
// decoder and its checker.
// ----------------------------------------------------------------------------
package ufd_pkg;

  // Result kinds as they appear on the output channel.
  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_NAME_END  = 3'd1,
    KIND_VALUE_END = 3'd2,
    KIND_ERROR     = 3'd3,
    KIND_DONE      = 3'd4
  } kind_t;

  // Which part of the body is being parsed.
  typedef enum logic [1:0] {
    PH_NAME  = 2'd0,
    PH_VALUE = 2'd1,
    PH_DROP  = 2'd2
  } phase_t;

  // Progress through a percent escape.
  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_t;

  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_PLUS    = 8'h2B;
  localparam logic [7:0] CHR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHR_AMP     = 8'h26;
  localparam logic [7:0] CHR_SPACE   = 8'h20;

  localparam int unsigned CFG_W   = 5;
  localparam logic [CFG_W-1:0] MAX_FIELDS_RESET = 5'd16;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  // Only meaningful for a character that passes is_hex.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

endpackage

// ===== rtl/core/ufd_in_if.sv =====
// ----------------------------------------------------------------------------
// Raw body byte channel
// Valid/ready channel carrying one raw byte of the body and its end flag.
// ----------------------------------------------------------------------------
interface ufd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/ufd_out_if.sv =====
// ----------------------------------------------------------------------------
// Decoded result channel
// Valid/ready channel carrying one decoded result of the form decoder.
// ----------------------------------------------------------------------------
interface ufd_out_if;
  import ufd_pkg::*;
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] out_byte;
  logic [3:0] field_index;
  logic       last;

  modport source (output valid, output kind, output out_byte, output field_index,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input field_index,
                  input last, output ready);
endinterface

// ===== rtl/core/ufd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a new value for the field limit register.
// ----------------------------------------------------------------------------
interface ufd_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] max_fields;

  modport source (output valid, output max_fields, input ready);
  modport sink   (input valid, input max_fields, output ready);
endinterface

// ===== rtl/core/urlencoded_form_decoder.sv =====
// ----------------------------------------------------------------------------
// Urlencoded form decoder
// Percent-decodes a form body one raw byte per transaction and emits decoded
// name and value bytes with end markers, an error or a done result.
// ----------------------------------------------------------------------------
//
//   Channel   Role   Transaction carries
//   --------  -----  ---------------------------------------------------
//   form_in   sink   in_byte, last_byte            (one raw body byte)
//   form_out  source kind, out_byte, field_index, last (one result)
//   cfg       sink   max_fields                    (field limit register)
//
// Each accepted byte is decoded combinationally into a bundle of up to seven
// result slots held in a register, which drains at one result per cycle while
// form_out is ready. A new byte is taken when the bundle is empty or its final
// result leaves, so bytes that give one result flow at one per cycle without
// stalls, and a byte that gives several results holds form_in until they drain.
// Reset (rst, synchronous, active high) returns the parser to the name phase,
// empties the bundle and sets the field limit to 16. A stall on form_out holds
// the current result and, once the bundle is down to its last result, also
// holds form_in. The configuration channel is always ready.
//
module urlencoded_form_decoder
  import ufd_pkg::*;
#(
  parameter int unsigned MAX_FIELDS = 16
) (
  input  logic     clk,
  input  logic     rst,
  ufd_in_if.sink   form_in,
  ufd_out_if.source form_out,
  ufd_cfg_if.sink  cfg
);

  // Pair counter is wide enough to hold the limit itself.
  localparam int unsigned PW = $clog2(MAX_FIELDS + 1);
  // Common width for comparing the counter against the limit.
  localparam int unsigned CW = (PW > CFG_W) ? PW : CFG_W;

  // Slot positions within one bundle, in output order.
  localparam int unsigned NSLOT       = 7;
  localparam int unsigned SLOT_PCT_A  = 0;  // '%' of an escape broken by this byte
  localparam int unsigned SLOT_HELD_A = 1;  // its held hex digit
  localparam int unsigned SLOT_MAIN   = 2;  // decoded byte or segment end marker
  localparam int unsigned SLOT_PCT_B  = 3;  // '%' of an escape cut by end of body
  localparam int unsigned SLOT_HELD_B = 4;  // its held hex digit
  localparam int unsigned SLOT_END    = 5;  // value end or error at end of body
  localparam int unsigned SLOT_DONE   = 6;  // done

  localparam int unsigned SW = $clog2(NSLOT);

  // Parser state.
  phase_t           phase, phase_next;
  esc_t             esc, esc_next;
  logic [7:0]       held, held_next;
  logic [PW-1:0]    pair_count, pair_next;
  logic [CFG_W-1:0] max_fields;

  // Result bundle register.
  logic [NSLOT-1:0] slot_valid;
  kind_t            slot_kind [NSLOT];
  logic [7:0]       slot_byte [NSLOT];
  logic [NSLOT-1:0] slot_last;
  logic [3:0]       bundle_idx;

  // Bundle being built from the incoming byte.
  logic [NSLOT-1:0] nv;
  kind_t            nk [NSLOT];
  logic [7:0]       nb [NSLOT];
  logic [NSLOT-1:0] nl;

  logic [CW-1:0]    limit;
  logic [PW-1:0]    pair_inc;
  phase_t           eff_phase;
  esc_t             eff_esc;
  esc_t             dec_esc;
  logic [7:0]       dec_held;
  logic [7:0]       delim;
  logic [7:0]       b;
  logic             lb;

  logic [SW-1:0]    sel;
  logic [NSLOT-1:0] sel_mask;
  logic             in_accept;
  logic             out_accept;

  // --------------------------------------------------------------------------
  // Output side: the lowest valid slot is the current result.
  // --------------------------------------------------------------------------
  always_comb begin
    sel = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (slot_valid[i]) sel = SW'(i);
    end
    sel_mask = slot_valid & (~slot_valid + NSLOT'(1));
  end

  assign out_accept = form_out.valid && form_out.ready;
  assign in_accept  = form_in.valid && form_in.ready;

  // The next byte may enter once nothing would be left after this cycle.
  assign form_in.ready = (slot_valid == '0) ||
                         (form_out.ready && ((slot_valid & ~sel_mask) == '0));

  assign form_out.valid       = |slot_valid;
  assign form_out.kind        = slot_kind[sel];
  assign form_out.out_byte    = slot_byte[sel];
  assign form_out.last        = slot_last[sel];
  assign form_out.field_index = (slot_kind[sel] == KIND_DONE) ? 4'd0 : bundle_idx;

  assign cfg.ready = 1'b1;

  // --------------------------------------------------------------------------
  // Decode of one byte into next parser state and a result bundle.
  // --------------------------------------------------------------------------
  assign b        = form_in.in_byte;
  assign lb       = form_in.last_byte;
  assign pair_inc = pair_count + PW'(1);

  always_comb begin
    limit = (CW'(max_fields) < CW'(MAX_FIELDS)) ? CW'(max_fields) : CW'(MAX_FIELDS);

    phase_next = phase;
    esc_next   = esc;
    held_next  = held;
    pair_next  = pair_count;

    nv = '0;
    nl = '0;
    for (int i = 0; i < NSLOT; i++) begin
      nk[i] = KIND_DATA;
      nb[i] = 8'h00;
    end

    // Reaching the limit drops the rest of the body; this is rechecked on
    // every byte so that a lowered limit takes effect mid-pair.
    eff_phase = phase;
    eff_esc   = esc;
    if (phase != PH_DROP && CW'(pair_count) >= limit) begin
      eff_phase = PH_DROP;
      eff_esc   = ESC_NONE;
    end

    delim    = (eff_phase == PH_NAME) ? CHR_EQUALS : CHR_AMP;
    dec_esc  = ESC_NONE;
    dec_held = held;

    case (eff_phase)
      PH_DROP: begin
        if (lb) begin
          nv[SLOT_DONE] = 1'b1;
          nk[SLOT_DONE] = KIND_DONE;
          nl[SLOT_DONE] = 1'b1;
          phase_next    = PH_NAME;
          esc_next      = ESC_NONE;
          held_next     = 8'h00;
          pair_next     = '0;
        end else begin
          phase_next = PH_DROP;
          esc_next   = ESC_NONE;
        end
      end

      default: begin
        if (b == delim) begin
          // A delimiter ends the segment even inside an escape, which is then
          // passed through literally ahead of the end marker.
          nv[SLOT_PCT_A]  = (eff_esc != ESC_NONE);
          nb[SLOT_PCT_A]  = CHR_PERCENT;
          nv[SLOT_HELD_A] = (eff_esc == ESC_DIGIT);
          nb[SLOT_HELD_A] = held;
          nv[SLOT_MAIN]   = 1'b1;
          esc_next        = ESC_NONE;
          if (eff_phase == PH_NAME) begin
            nk[SLOT_MAIN] = KIND_NAME_END;
            phase_next    = PH_VALUE;
            if (lb) begin
              nv[SLOT_END]  = 1'b1;
              nk[SLOT_END]  = KIND_VALUE_END;
              nv[SLOT_DONE] = 1'b1;
              nk[SLOT_DONE] = KIND_DONE;
              nl[SLOT_DONE] = 1'b1;
              phase_next    = PH_NAME;
              held_next     = 8'h00;
              pair_next     = '0;
            end
          end else begin
            nk[SLOT_MAIN] = KIND_VALUE_END;
            phase_next    = PH_NAME;
            pair_next     = pair_inc;
            if (lb) begin
              nv[SLOT_DONE] = 1'b1;
              nk[SLOT_DONE] = KIND_DONE;
              nl[SLOT_DONE] = 1'b1;
              held_next     = 8'h00;
              pair_next     = '0;
            end else if (CW'(pair_inc) >= limit) begin
              phase_next = PH_DROP;
            end
          end
        end else begin
          if (eff_esc == ESC_PCT && is_hex(b)) begin
            // First hex digit of an escape is held back.
            dec_esc  = ESC_DIGIT;
            dec_held = b;
          end else if (eff_esc == ESC_DIGIT && is_hex(b)) begin
            nv[SLOT_MAIN] = 1'b1;
            nb[SLOT_MAIN] = {hex_val(held), hex_val(b)};
          end else begin
            // A broken escape is passed through, then the byte is taken fresh.
            nv[SLOT_PCT_A]  = (eff_esc != ESC_NONE);
            nb[SLOT_PCT_A]  = CHR_PERCENT;
            nv[SLOT_HELD_A] = (eff_esc == ESC_DIGIT);
            nb[SLOT_HELD_A] = held;
            if (b == CHR_PERCENT) begin
              dec_esc = ESC_PCT;
            end else begin
              nv[SLOT_MAIN] = 1'b1;
              nb[SLOT_MAIN] = (b == CHR_PLUS) ? CHR_SPACE : b;
            end
          end

          if (lb) begin
            // End of body: flush whatever escape is left, then close.
            nv[SLOT_PCT_B]  = (dec_esc != ESC_NONE);
            nb[SLOT_PCT_B]  = CHR_PERCENT;
            nv[SLOT_HELD_B] = (dec_esc == ESC_DIGIT);
            nb[SLOT_HELD_B] = dec_held;
            nv[SLOT_END]    = 1'b1;
            if (eff_phase == PH_NAME) begin
              nk[SLOT_END] = KIND_ERROR;
              nl[SLOT_END] = 1'b1;
            end else begin
              nk[SLOT_END]  = KIND_VALUE_END;
              nv[SLOT_DONE] = 1'b1;
              nk[SLOT_DONE] = KIND_DONE;
              nl[SLOT_DONE] = 1'b1;
            end
            phase_next = PH_NAME;
            esc_next   = ESC_NONE;
            held_next  = 8'h00;
            pair_next  = '0;
          end else begin
            phase_next = eff_phase;
            esc_next   = dec_esc;
            held_next  = dec_held;
          end
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State and configuration registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_NAME;
      esc        <= ESC_NONE;
      held       <= 8'h00;
      pair_count <= '0;
      max_fields <= MAX_FIELDS_RESET;
    end else begin
      if (in_accept) begin
        phase      <= phase_next;
        esc        <= esc_next;
        held       <= held_next;
        pair_count <= pair_next;
      end
      if (cfg.valid && cfg.ready) begin
        max_fields <= cfg.max_fields;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result bundle register. A new bundle replaces the old one only when the
  // old one is empty or its final result leaves in this cycle.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (in_accept) begin
      slot_valid <= nv;
    end else if (out_accept) begin
      slot_valid <= slot_valid & ~sel_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < NSLOT; i++) begin
        slot_kind[i] <= nk[i];
        slot_byte[i] <= nb[i];
      end
      slot_last  <= nl;
      bundle_idx <= 4'(pair_count);
    end
  end

endmodule

// ===== rtl/core/ufd_checker.sv =====
// ----------------------------------------------------------------------------
// Form decoder checker
// Port-level assertions on the result channel of the form decoder.
// ----------------------------------------------------------------------------
module ufd_checker
  import ufd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [7:0] out_byte,
  input logic [3:0] out_field_index,
  input logic       out_last
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte) &&
      $stable(out_field_index) && $stable(out_last))
    else $error("result changed while stalled");

  // Only an error or done closes a body, and both always do.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_kind == KIND_ERROR || out_kind == KIND_DONE)))
    else $error("last flag does not match result kind");

  // Markers carry no byte.
  a_marker_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_DATA |-> out_byte == 8'h00)
    else $error("marker result carries a byte");

  // Done belongs to no pair.
  a_done_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_DONE |-> out_field_index == 4'd0)
    else $error("done result has a field index");

endmodule

bind urlencoded_form_decoder ufd_checker u_ufd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (form_out.valid),
  .out_ready      (form_out.ready),
  .out_kind       (form_out.kind),
  .out_byte       (form_out.out_byte),
  .out_field_index(form_out.field_index),
  .out_last       (form_out.last)
);

// ===== dv/tb_urlencoded_form_decoder.sv =====
// ----------------------------------------------------------------------------
// Urlencoded form decoder testbench
// Sends form bodies byte by byte, predicts every decoded result in the bench
// and checks each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
//
// The bench keeps its own copy of the parser state and the field limit. It
// updates the state on each accepted body byte and the limit on each write,
// and queues the results each accepted byte should produce. A monitor pops
// one prediction per result transaction and compares it field by field.
//
// Stimulus runs in four parts. First a directed set covers escapes, '+' as a
// space, delimiters inside an escape, broken escapes and every way a body can
// end. Then the field limit is exercised: a limit of one, zero, two and the
// top value. One body reaches the parameter ceiling, and one has the limit
// lowered part way through a pair. Last come random bodies, mostly
// well-formed with random content and some pure noise, first with random
// gaps on both channels and then as a stretch with no gaps at all.
//
module tb_urlencoded_form_decoder;
  import ufd_pkg::*;

  localparam int unsigned MAX_FIELDS    = 16;
  localparam int          SETTLE_CYCLES = 10;
  localparam int          NOISY_ITEMS   = 190;
  localparam int          QUIET_ITEMS   = 80;

  typedef logic [7:0] body_t [$];

  // One predicted or observed result.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [3:0] field;
    logic       fin;
  } form_result_t;

  logic clk = 1'b0;
  logic rst;

  ufd_in_if  raw_bus ();
  ufd_out_if result_bus ();
  ufd_cfg_if limit_bus ();

  urlencoded_form_decoder #(
    .MAX_FIELDS(MAX_FIELDS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .form_in  (raw_bus),
    .form_out (result_bus),
    .cfg      (limit_bus)
  );

  // Clock with a period of 12 time units.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bench copy of the parser state and of the field limit register.
  phase_t     dec_phase;
  esc_t       dec_esc;
  logic [7:0] dec_held;
  logic [4:0] dec_pairs;
  logic [4:0] field_limit;

  // Results still owed by the block, oldest first.
  form_result_t pending_results [$];

  bit send_idle_en;
  bit sink_stall_en;

  int mismatches;
  int bytes_sent;
  int bodies_sent;
  int limit_writes;
  int results_checked;
  int errors_seen;
  int dones_seen;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "a")
      v = c - "a" + 8'd10;
    else if (c >= "A")
      v = c - "A" + 8'd10;
    else
      v = c - "0";
    return v[3:0];
  endfunction

  task automatic push_result(input kind_t k, input logic [7:0] d, input logic [3:0] f,
                             input logic fin);
    form_result_t r;
    r.kind  = k;
    r.data  = (k == KIND_DATA) ? d : 8'h00;
    r.field = f;
    r.fin   = fin;
    pending_results.push_back(r);
  endtask

  task automatic clear_body();
    dec_phase = PH_NAME;
    dec_esc   = ESC_NONE;
    dec_held  = 8'h00;
    dec_pairs = 5'd0;
  endtask

  // An unfinished escape goes out literally: the '%' and any digit held.
  task automatic flush_open_escape(input logic [3:0] idx);
    if (dec_esc != ESC_NONE)
      push_result(KIND_DATA, CHR_PERCENT, idx, 1'b0);
    if (dec_esc == ESC_DIGIT)
      push_result(KIND_DATA, dec_held, idx, 1'b0);
    dec_esc = ESC_NONE;
  endtask

  // Percent and plus decoding of one byte inside a name or a value.
  task automatic decode_segment_byte(input logic [7:0] b, input logic [3:0] idx);
    if (dec_esc == ESC_PCT) begin
      if (is_hex_char(b)) begin
        dec_held = b;
        dec_esc  = ESC_DIGIT;
        return;
      end
      flush_open_escape(idx);
    end else if (dec_esc == ESC_DIGIT) begin
      if (is_hex_char(b)) begin
        push_result(KIND_DATA, {hex_nibble(dec_held), hex_nibble(b)}, idx, 1'b0);
        dec_esc = ESC_NONE;
        return;
      end
      flush_open_escape(idx);
    end
    // The byte that broke an escape is handled here as a fresh byte.
    if (b == CHR_PERCENT)
      dec_esc = ESC_PCT;
    else if (b == CHR_PLUS)
      push_result(KIND_DATA, CHR_SPACE, idx, 1'b0);
    else
      push_result(KIND_DATA, b, idx, 1'b0);
  endtask

  // Advances the bench state by one accepted body byte and queues its results.
  task automatic decode_form_byte(input logic [7:0] b, input logic lb);
    logic [4:0] lim;
    logic [3:0] idx;
    logic [7:0] delim;
    lim = (field_limit < MAX_FIELDS) ? field_limit : 5'(MAX_FIELDS);
    idx = dec_pairs[3:0];

    // The limit is checked on every byte, so lowering it mid-pair abandons
    // the open pair without an end marker.
    if (dec_phase != PH_DROP && dec_pairs >= lim) begin
      dec_phase = PH_DROP;
      dec_esc   = ESC_NONE;
    end
    if (dec_phase == PH_DROP) begin
      if (lb) begin
        push_result(KIND_DONE, 8'h00, 4'd0, 1'b1);
        clear_body();
      end
      return;
    end

    delim = (dec_phase == PH_NAME) ? CHR_EQUALS : CHR_AMP;
    if (b == delim) begin
      flush_open_escape(idx);
      if (dec_phase == PH_NAME) begin
        push_result(KIND_NAME_END, 8'h00, idx, 1'b0);
        dec_phase = PH_VALUE;
        if (lb) begin
          push_result(KIND_VALUE_END, 8'h00, idx, 1'b0);
          push_result(KIND_DONE, 8'h00, 4'd0, 1'b1);
          clear_body();
        end
      end else begin
        push_result(KIND_VALUE_END, 8'h00, idx, 1'b0);
        dec_pairs = dec_pairs + 5'd1;
        dec_phase = PH_NAME;
        if (lb) begin
          push_result(KIND_DONE, 8'h00, 4'd0, 1'b1);
          clear_body();
        end else if (dec_pairs >= lim) begin
          dec_phase = PH_DROP;
        end
      end
      return;
    end

    decode_segment_byte(b, idx);
    if (lb) begin
      flush_open_escape(idx);
      if (dec_phase == PH_NAME) begin
        // The body ended inside a name.
        push_result(KIND_ERROR, 8'h00, idx, 1'b1);
      end else begin
        push_result(KIND_VALUE_END, 8'h00, idx, 1'b0);
        push_result(KIND_DONE, 8'h00, 4'd0, 1'b1);
      end
      clear_body();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  // The sink stalls with a chance of about nine in a hundred while stalling is on.
  always @(posedge clk) begin
    result_bus.ready <= !(sink_stall_en && $urandom_range(0, 99) < 9);
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    form_result_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, actual kind %0d byte %0h field %0d last %0b",
                 $time, result_bus.kind, result_bus.out_byte, result_bus.field_index,
                 result_bus.last);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 8'(want.kind), 8'(result_bus.kind));
        check_field("out_byte", want.data, result_bus.out_byte);
        check_field("field_index", 8'(want.field), 8'(result_bus.field_index));
        check_field("last", 8'(want.fin), 8'(result_bus.last));
        results_checked++;
        if (want.kind == KIND_ERROR)
          errors_seen++;
        if (want.kind == KIND_DONE)
          dones_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Sends one body byte and predicts its results once the transaction is
  // accepted. Valid is left high so that back-to-back bytes stream.
  task automatic send_byte(input logic [7:0] b, input logic lb);
    while (send_idle_en && $urandom_range(0, 99) < 9) begin
      raw_bus.valid <= 1'b0;
      @(posedge clk);
    end
    raw_bus.valid     <= 1'b1;
    raw_bus.in_byte   <= b;
    raw_bus.last_byte <= lb;
    do @(posedge clk); while (!raw_bus.ready);
    decode_form_byte(b, lb);
    bytes_sent++;
  endtask

  // The final byte is marked as the end of the body unless the body is to be
  // continued later.
  task automatic send_body(input body_t body, input bit closes = 1'b1);
    foreach (body[i])
      send_byte(body[i], closes && (i == body.size() - 1));
    if (closes)
      bodies_sent++;
  endtask

  // Holds the sender back until every predicted result has come, then lets a
  // few more cycles pass in case a byte without results is still in flight.
  task automatic wait_idle();
    raw_bus.valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [4:0] v);
    wait_idle();
    limit_bus.valid      <= 1'b1;
    limit_bus.max_fields <= v;
    do @(posedge clk); while (!limit_bus.ready);
    limit_bus.valid <= 1'b0;
    field_limit = v;
    limit_writes++;
  endtask

  function automatic body_t text_body(input string s);
    body_t q;
    foreach (s[i])
      q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] random_hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10)
      return "0" + 8'(v);
    else if (v < 16)
      return "A" + 8'(v - 10);
    return "a" + 8'(v - 16);
  endfunction

  // Adds a random name or value of up to five tokens. Most tokens are plain
  // characters, hex digits and complete escapes; some are lone '%', '+', the
  // delimiter of the other segment or an arbitrary byte.
  task automatic add_segment(inout body_t q, input bit in_name);
    int r;
    repeat ($urandom_range(0, 5)) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        q.push_back("a" + 8'($urandom_range(0, 25)));
      end else if (r < 50) begin
        q.push_back(random_hex_char());
      end else if (r < 65) begin
        q.push_back(CHR_PERCENT);
        q.push_back(random_hex_char());
        q.push_back(random_hex_char());
      end else if (r < 73) begin
        q.push_back(CHR_PERCENT);
      end else if (r < 80) begin
        q.push_back(CHR_PLUS);
      end else if (r < 86) begin
        q.push_back(in_name ? CHR_AMP : CHR_EQUALS);
      end else begin
        q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Builds a random body, ending in one of the four ways a body can end.
  task automatic build_random_body(output body_t q);
    int npairs;
    q = {};
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8))
        q.push_back(8'($urandom_range(0, 255)));
    end else begin
      npairs = $urandom_range(1, 4);
      for (int p = 0; p < npairs; p++) begin
        add_segment(q, 1'b1);
        q.push_back(CHR_EQUALS);
        add_segment(q, 1'b0);
        if (p < npairs - 1)
          q.push_back(CHR_AMP);
      end
      case ($urandom_range(0, 3))
        1: q.push_back(CHR_AMP);
        2: begin
          add_segment(q, 1'b1);
          q.push_back(CHR_EQUALS);
        end
        3: begin
          q.push_back(CHR_AMP);
          q.push_back("n");
          add_segment(q, 1'b1);
        end
        default: ;
      endcase
    end
  endtask

  // Mostly the reset limit, else one, two, three or any value, so that dropping is reached often.
  function automatic logic [4:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return 5'd1;
      1: return 5'd2;
      2: return 5'd3;
      3: return 5'($urandom_range(0, 31));
      default: return MAX_FIELDS_RESET;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Escapes, '+' as a space, delimiters inside an escape, broken escapes,
  // extreme byte values and every way a body can end.
  task automatic test_escapes_and_endings();
    body_t q;
    send_body(text_body("%4=+%g&"));
    send_body(text_body("%%4a=%2F%7e"));
    send_body(text_body("a="));
    q = {8'h00, 8'hFF};
    send_body(q);
    send_body(text_body("%=%"));
  endtask

  // Limits of one, zero and two, the top register value with a body that
  // reaches the parameter ceiling, and a limit lowered part way through a
  // pair.
  task automatic test_field_limit();
    body_t q;
    write_limit(5'd1);
    send_body(text_body("a=b&c=d"));
    write_limit(5'd0);
    send_body(text_body("ab"));
    write_limit(5'd2);
    send_body(text_body("a=1&b=2&"));
    write_limit(5'd31);
    q = {};
    repeat (MAX_FIELDS) begin
      q.push_back(CHR_EQUALS);
      q.push_back(CHR_AMP);
    end
    q.push_back("x");
    send_body(q);
    write_limit(MAX_FIELDS_RESET);
    send_body(text_body("a=b&c"), 1'b0);
    write_limit(5'd1);
    send_body(text_body("d"));
    write_limit(MAX_FIELDS_RESET);
  endtask

  task automatic run_random_bodies(input int n_bytes);
    body_t q;
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(0, 3) == 0)
        write_limit(pick_limit());
      build_random_body(q);
      send_body(q);
    end
  endtask

  task automatic test_random_bodies();
    send_idle_en  = 1'b1;
    sink_stall_en = 1'b1;
    run_random_bodies(NOISY_ITEMS);
  endtask

  // The same random traffic with no gaps on either channel.
  task automatic test_back_to_back();
    send_idle_en  = 1'b0;
    sink_stall_en = 1'b0;
    run_random_bodies(QUIET_ITEMS);
    send_idle_en  = 1'b1;
    sink_stall_en = 1'b1;
  endtask

  initial begin
    rst                  = 1'b1;
    raw_bus.valid        = 1'b0;
    raw_bus.in_byte      = 8'h00;
    raw_bus.last_byte    = 1'b0;
    result_bus.ready     = 1'b0;
    limit_bus.valid      = 1'b0;
    limit_bus.max_fields = MAX_FIELDS_RESET;
    send_idle_en         = 1'b1;
    sink_stall_en        = 1'b1;
    mismatches           = 0;
    bytes_sent           = 0;
    bodies_sent          = 0;
    limit_writes         = 0;
    results_checked      = 0;
    errors_seen          = 0;
    dones_seen           = 0;
    field_limit          = MAX_FIELDS_RESET;
    clear_body();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_escapes_and_endings();
    test_field_limit();
    test_random_bodies();
    test_back_to_back();

    wait_idle();
    $display("Decoded %0d bodies of %0d bytes over %0d limit writes.",
             bodies_sent, bytes_sent, limit_writes);
    $display("Compared %0d results, %0d of them truncated-name errors and %0d done markers.",
             results_checked, errors_seen, dones_seen);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Guards against a hang on either channel.
  initial begin
    #4000000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
